// ----- rtl/cua_pkg.sv -----
// Shared types and codes for the contiguous unit allocator.
// Holds operation, status, fit-mode and register codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package cua_pkg;

  // Operation codes of an input item
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_TICK    = 2'd3;

  // Placement policies; the unused code acts as first-fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  // Register indexes, taken from paddr[2]
  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_UNITS    = 1'b1;

  // Reset value of the unit count register
  localparam logic [8:0] UNITS_RESET = 9'd256;

  // Sequencer states
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_WRITE  = 6'b001000,
    S_TICK   = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

endpackage

// ----- rtl/contiguous_unit_allocator.sv -----
// Contiguous unit allocator: unit map memory, scan/write/tick sequencer, APB registers.
// Depends on cua_pkg.
`timescale 1ns / 1ps

// Keeps a map of MAX_UNITS units, each holding a remaining lifetime (0 = free), in
// one single-port-write, registered-read memory. After reset a clearing pass writes
// every unit to zero, one unit a cycle; no item is taken then. One item is worked
// at a time; the input stalls until the sequencer is idle again. A tick walks the n
// active units through a pipelined read-modify-write. An allocate scans the map one
// unit a cycle (next-fit makes a second pass from unit 0 when it wraps; first- and
// next-fit stop at the first fit), then writes the run, one unit a cycle. An invalid
// request goes straight to the result. A finished result waits in an output register
// while the next item is accepted.
module contiguous_unit_allocator
  import cua_pkg::*;
#(
  parameter int MAX_UNITS = 256,
  parameter int LIFE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [8:0]  size_units_i,
  input  logic [15:0] lifetime_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  base_unit_o,
  output logic [8:0]  occupied_units_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_UNITS);
  localparam int CW = $clog2(MAX_UNITS + 1);
  localparam int NW = (CW > 9) ? CW : 9;
  localparam logic [32:0] LIFE_MAX_W = (33'd1 << LIFE_BITS) - 33'd1;

  // Control registers
  state_e         state_q, state_d;
  logic [NW-1:0]  idx_q, idx_d;
  logic           chk_vld_q, chk_vld_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic           found_q, found_d;
  logic           pass2_q, pass2_d;
  logic           out_valid_q, out_valid_d;
  logic [1:0]     fit_mode_q, fit_mode_d;
  logic [8:0]     units_q, units_d;

  // Payload registers
  logic [AW-1:0]        chk_idx_q, chk_idx_d;
  logic [NW-1:0]        run_len_q, run_len_d;
  logic [AW-1:0]        run_start_q, run_start_d;
  logic [NW-1:0]        best_len_q, best_len_d;
  logic [AW-1:0]        best_at_q, best_at_d;
  logic [8:0]           size_q, size_d;
  logic [LIFE_BITS-1:0] life_q, life_d;
  logic [AW-1:0]        wr_idx_q, wr_idx_d;
  logic [8:0]           cnt_q, cnt_d;
  logic [AW-1:0]        at_q, at_d;
  logic [NW-1:0]        occ_q, occ_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [1:0]           out_status_q;
  logic [7:0]           out_base_q;
  logic [8:0]           out_occ_q;

  // Unit map memory
  logic [LIFE_BITS-1:0] mem [MAX_UNITS];
  logic [LIFE_BITS-1:0] rd_data_q;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [LIFE_BITS-1:0] mem_wd;

  // Datapath helpers
  logic [NW-1:0]        n_w;
  logic [NW-1:0]        size_n;
  logic [NW-1:0]        run_inc;
  logic                 issue;
  logic                 free;
  logic                 best_mode;
  logic                 next_mode;
  logic                 end_fits;
  logic                 out_load;
  logic [AW-1:0]        ptr_norm;
  logic [32:0]          life_w;
  logic [LIFE_BITS-1:0] life_sat;
  logic [31:0]          base_w;
  logic [31:0]          occ_w;
  logic                 cfg_wr;

  // Saturate the unit count and the requested lifetime
  assign n_w      = (NW'(units_q) > NW'(MAX_UNITS)) ? NW'(MAX_UNITS) : NW'(units_q);
  assign size_n   = NW'(size_q);
  assign life_w   = 33'(lifetime_i);
  assign life_sat = (life_w > LIFE_MAX_W) ? LIFE_MAX_W[LIFE_BITS-1:0]
                                          : life_w[LIFE_BITS-1:0];
  assign ptr_norm = (NW'(ptr_q) >= n_w) ? '0 : ptr_q;

  // Shared compare unit inputs
  assign issue     = (idx_q < n_w);
  assign free      = (rd_data_q == '0);
  assign run_inc   = run_len_q + NW'(1);
  assign best_mode = (fit_mode_q == FIT_BEST);
  assign next_mode = (fit_mode_q == FIT_NEXT);
  assign end_fits  = (run_len_q >= size_n) && (!found_q || (run_len_q < best_len_q));

  assign cfg_wr = psel && penable && pwrite;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = idx_q[AW-1:0];
    ptr_d        = ptr_q;
    found_d      = found_q;
    pass2_d      = pass2_q;
    out_valid_d  = out_valid_q;
    fit_mode_d   = fit_mode_q;
    units_d      = units_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_at_d    = best_at_q;
    size_d       = size_q;
    life_d       = life_q;
    wr_idx_d     = wr_idx_q;
    cnt_d        = cnt_q;
    at_d         = at_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    rd_addr      = idx_q[AW-1:0];
    mem_we       = 1'b0;
    mem_wa       = idx_q[AW-1:0];
    mem_wd       = '0;

    // Drop the result once it is taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Register writes
    if (cfg_wr) begin
      case (paddr[2])
        REG_FIT_MODE: fit_mode_d = pwdata[1:0];
        default:      units_d    = pwdata[8:0];
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_q[AW-1:0];
        idx_d  = idx_q + NW'(1);
        if (idx_q[AW-1:0] == AW'(MAX_UNITS - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          size_d    = size_units_i;
          life_d    = life_sat;
          idx_d     = '0;
          occ_d     = '0;
          at_d      = '0;
          run_len_d = '0;
          found_d   = 1'b0;
          pass2_d   = 1'b0;
          if (func_i == FUNC_TICK) begin
            state_d = S_TICK;
          end else if (size_units_i == '0 || lifetime_i == '0) begin
            res_status_d = ST_INVALID;
            state_d      = S_RESULT;
          end else begin
            if (next_mode) begin
              ptr_d = ptr_norm;
              idx_d = NW'(ptr_norm);
            end
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          chk_vld_d = 1'b1;
          idx_d     = idx_q + NW'(1);
        end
        if (chk_vld_q) begin
          if (free) begin
            run_len_d = run_inc;
            if (run_len_q == '0) begin
              run_start_d = chk_idx_q;
            end
            // First and next fit stop at the first run that reaches the size
            if (!best_mode && run_inc >= size_n) begin
              at_d      = (run_len_q == '0) ? chk_idx_q : run_start_q;
              wr_idx_d  = (run_len_q == '0) ? chk_idx_q : run_start_q;
              cnt_d     = size_q;
              chk_vld_d = 1'b0;
              state_d   = S_WRITE;
            end
          end else begin
            run_len_d = '0;
            if (best_mode && end_fits) begin
              found_d    = 1'b1;
              best_len_d = run_len_q;
              best_at_d  = run_start_q;
            end
          end
        end else if (!issue) begin
          // Scan finished: close the trailing run, retry or fail
          if (best_mode && (found_q || end_fits)) begin
            at_d     = end_fits ? run_start_q : best_at_q;
            wr_idx_d = end_fits ? run_start_q : best_at_q;
            cnt_d    = size_q;
            state_d  = S_WRITE;
          end else if (next_mode && !pass2_q && ptr_q != '0) begin
            pass2_d   = 1'b1;
            idx_d     = '0;
            run_len_d = '0;
          end else begin
            res_status_d = ST_NO_FIT;
            at_d         = '0;
            state_d      = S_RESULT;
          end
        end
      end

      S_WRITE: begin
        mem_we   = 1'b1;
        mem_wa   = wr_idx_q;
        mem_wd   = life_q;
        wr_idx_d = wr_idx_q + AW'(1);
        cnt_d    = cnt_q - 9'd1;
        if (cnt_q == 9'd1) begin
          if (next_mode) begin
            ptr_d = wr_idx_q;
          end
          res_status_d = ST_GRANTED;
          state_d      = S_RESULT;
        end
      end

      S_TICK: begin
        if (issue) begin
          chk_vld_d = 1'b1;
          idx_d     = idx_q + NW'(1);
        end
        if (chk_vld_q) begin
          if (!free) begin
            mem_we = 1'b1;
            mem_wa = chk_idx_q;
            mem_wd = rd_data_q - LIFE_BITS'(1);
            occ_d  = occ_q + NW'(1);
          end
        end else if (!issue) begin
          res_status_d = ST_TICK;
          state_d      = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fit_mode_q  <= FIT_FIRST;
      units_q     <= UNITS_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_vld_q   <= chk_vld_d;
      ptr_q       <= ptr_d;
      found_q     <= found_d;
      pass2_q     <= pass2_d;
      out_valid_q <= out_valid_d;
      fit_mode_q  <= fit_mode_d;
      units_q     <= units_d;
    end
  end

  // Hold payload
  assign base_w = (res_status_q == ST_GRANTED) ? 32'(at_q) : 32'd0;
  assign occ_w  = (res_status_q == ST_TICK) ? 32'(occ_q) : 32'd0;

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    best_len_q   <= best_len_d;
    best_at_q    <= best_at_d;
    size_q       <= size_d;
    life_q       <= life_d;
    wr_idx_q     <= wr_idx_d;
    cnt_q        <= cnt_d;
    at_q         <= at_d;
    occ_q        <= occ_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_base_q   <= base_w[7:0];
      out_occ_q    <= occ_w[8:0];
    end
  end

  // Unit map: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Ports
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign base_unit_o      = out_base_q;
  assign occupied_units_o = out_occ_q;
  assign pready           = 1'b1;
  assign prdata           = (paddr[2] == REG_UNITS) ? 32'(units_q) : 32'(fit_mode_q);

`ifndef SYNTHESIS
  // A run is never written at or beyond the active unit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (NW'(wr_idx_q) < n_w))
    else $error("run write beyond active units");

  // Base unit is zero on every result but a grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_GRANTED) |-> (base_unit_o == 8'd0))
    else $error("base unit set on a non-grant result");

  // Occupied count is zero on every result but a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_TICK) |-> (occupied_units_o == 9'd0))
    else $error("occupied count set on a non-tick result");

  // An accepted item closes the input until its result is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after a transfer");
`endif

endmodule

// ----- tb/cua_result_checker.sv -----
// Result checker for the contiguous unit allocator: mirrors the unit map and registers,
// predicts each result from the accepted items and compares it with the block's output.
// Depends on cua_pkg.
`timescale 1ns / 1ps

module cua_result_checker
  import cua_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [8:0]  size_units_i,
  input  logic [15:0] lifetime_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  base_unit_i,
  input  logic [8:0]  occupied_units_i,
  // register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // totals for the test top
  output int          fail_count_o,
  output int          pending_o
);

  localparam int MAP_UNITS = 256;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] base_unit;
    logic [8:0] occupied_units;
  } alloc_result_t;

  // Mirror of the unit map, the next-fit pointer and the registers
  logic [15:0]   life_map [MAP_UNITS];
  int            next_ptr;
  logic [1:0]    fit_mode;
  logic [8:0]    unit_limit;
  alloc_result_t pending_results [$];
  int            fail_count;
  int            pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  // Length of the free run starting at unit s, bounded by n
  function automatic int free_run_length(int s, int n);
    int k;
    k = s;
    while (k < n && life_map[k] == 16'd0) k++;
    return k - s;
  endfunction

  // Lowest start in [lo, hi) whose free run holds size units
  function automatic bit find_first_run(int lo, int hi, int n, int size, output int at);
    int i;
    int len;
    at = 0;
    i = lo;
    while (i < hi) begin
      if (life_map[i] != 16'd0) begin
        i++;
      end else begin
        len = free_run_length(i, n);
        if (len >= size) begin
          at = i;
          return 1'b1;
        end
        // no later start inside this run can be longer
        i += len;
      end
    end
    return 1'b0;
  endfunction

  // Work out the result of one item and update the mirrored map
  function automatic alloc_result_t place_or_tick(logic func, logic [8:0] size_in,
                                                  logic [15:0] life);
    alloc_result_t r;
    int n;
    int size;
    int at;
    int len;
    int best_len;
    int i;
    int occ;
    bit found;
    r = '0;
    n = (unit_limit > MAP_UNITS) ? MAP_UNITS : int'(unit_limit);
    size = int'(size_in);
    at = 0;
    found = 1'b0;

    if (func == FUNC_TICK) begin
      occ = 0;
      for (i = 0; i < n; i++) begin
        if (life_map[i] != 16'd0) begin
          occ++;
          life_map[i] = life_map[i] - 16'd1;
        end
      end
      r.status = ST_TICK;
      r.occupied_units = occ[8:0];
      return r;
    end

    if (size == 0 || life == 16'd0) begin
      r.status = ST_INVALID;
      return r;
    end

    case (fit_mode)
      FIT_NEXT: begin
        if (next_ptr >= n) next_ptr = 0;
        found = find_first_run(next_ptr, n, n, size, at);
        if (!found) found = find_first_run(0, next_ptr, n, size, at);
      end
      FIT_BEST: begin
        i = 0;
        best_len = 0;
        while (i < n) begin
          if (life_map[i] != 16'd0) begin
            i++;
          end else begin
            len = free_run_length(i, n);
            if (len >= size && (!found || len < best_len)) begin
              found = 1'b1;
              best_len = len;
              at = i;
            end
            i += len;
          end
        end
      end
      default: begin
        found = find_first_run(0, n, n, size, at);
      end
    endcase

    if (!found) begin
      r.status = ST_NO_FIT;
      return r;
    end

    for (i = at; i < at + size && i < n; i++) life_map[i] = life;
    if (fit_mode == FIT_NEXT) next_ptr = at + size - 1;
    r.status = ST_GRANTED;
    r.base_unit = at[7:0];
    return r;
  endfunction

  // Compare each result transfer, predict each item transfer, track register writes
  always @(posedge clk_i or negedge rst_ni) begin : track
    int i;
    alloc_result_t want;
    if (!rst_ni) begin
      for (i = 0; i < MAP_UNITS; i++) life_map[i] = 16'd0;
      next_ptr = 0;
      fit_mode = FIT_FIRST;
      unit_limit = UNITS_RESET;
      pending_results.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d base %0d occupied %0d",
                   $time, status_i, base_unit_i, occupied_units_i);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
            fail_count++;
          end
          if (base_unit_i !== want.base_unit) begin
            $display("%0t: base_unit expected %0d, got %0d",
                     $time, want.base_unit, base_unit_i);
            fail_count++;
          end
          if (occupied_units_i !== want.occupied_units) begin
            $display("%0t: occupied_units expected %0d, got %0d",
                     $time, want.occupied_units, occupied_units_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(place_or_tick(func_i, size_units_i, lifetime_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_FIT_MODE) fit_mode = pwdata_i[1:0];
        else unit_limit = pwdata_i[8:0];
      end
      pending_count = pending_results.size();
    end
  end

endmodule

// ----- tb/contiguous_unit_allocator_test.sv -----
// Test top for the contiguous unit allocator: clock, reset, item and register stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on cua_pkg, contiguous_unit_allocator and cua_result_checker.
`timescale 1ns / 1ps

module contiguous_unit_allocator_test;
  import cua_pkg::*;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_CYCLES     = 3000;
  localparam int TAIL_CYCLES     = 1000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 96;
  // unused fit code, handled as first-fit
  localparam logic [1:0] FIT_SPARE = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        func       = FUNC_ALLOC;
  logic [8:0]  size_units = '0;
  logic [15:0] lifetime   = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  status;
  logic [7:0]  base_unit;
  logic [8:0]  occupied_units;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  bit          no_idle      = 1'b0;
  bit          hold_request = 1'b0;

  logic [1:0] fit_plan  [PHASES] = '{FIT_FIRST, FIT_NEXT, FIT_BEST, FIT_SPARE,
                                     FIT_NEXT, FIT_BEST, FIT_NEXT, FIT_FIRST,
                                     FIT_BEST, FIT_NEXT, FIT_FIRST, FIT_BEST};
  logic [8:0] unit_plan [PHASES] = '{9'd256, 9'd8, 9'd1, 9'd32, 9'd2, 9'd256,
                                     9'd16, 9'd0, 9'd64, 9'd300, 9'd5, 9'd256};

  always #5 clk = ~clk;

  contiguous_unit_allocator u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .size_units_i     (size_units),
    .lifetime_i       (lifetime),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .base_unit_o      (base_unit),
    .occupied_units_o (occupied_units),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  cua_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (func),
    .size_units_i     (size_units),
    .lifetime_i       (lifetime),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .base_unit_i      (base_unit),
    .occupied_units_i (occupied_units),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Mostly short gaps, a few long ones, none while no_idle is set
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic f, input logic [8:0] sz, input logic [15:0] lt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    size_units <= sz;
    lifetime   <= lt;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // A setup phase and an access phase; psel stays up for a following access
  task automatic write_reg(input logic reg_index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Write both registers once the block is idle
  task automatic set_config(input logic [1:0] fit, input logic [8:0] units);
    drain_results();
    write_reg(REG_FIT_MODE, {30'd0, fit});
    write_reg(REG_UNITS, {23'd0, units});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Take results with random stalls; one long hold-off on request
  initial begin : result_sink
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int k;
    int n;
    int r;
    int top_size;
    logic [8:0]  sz;
    logic [15:0] lt;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Invalid requests, empty tick, whole-map grant and rejection
    send_item(FUNC_ALLOC, 9'd0, 16'hFFFF);
    send_item(FUNC_ALLOC, 9'd5, 16'd0);
    send_item(FUNC_TICK, 9'h1FF, 16'hFFFF);
    send_item(FUNC_ALLOC, 9'd256, 16'd2);
    send_item(FUNC_ALLOC, 9'd1, 16'd1);
    send_item(FUNC_ALLOC, 9'h1FF, 16'd7);
    send_item(FUNC_TICK, 9'd0, 16'd0);
    send_item(FUNC_TICK, 9'd0, 16'd0);
    // Build a small hole for best-fit
    send_item(FUNC_ALLOC, 9'd3, 16'd4);
    send_item(FUNC_ALLOC, 9'd2, 16'd1);
    send_item(FUNC_ALLOC, 9'd4, 16'd9);
    send_item(FUNC_TICK, 9'd0, 16'd0);
    set_config(FIT_BEST, 9'd256);
    send_item(FUNC_ALLOC, 9'd2, 16'd5);
    set_config(FIT_NEXT, 9'd256);
    send_item(FUNC_ALLOC, 9'd1, 16'd3);
    send_item(FUNC_ALLOC, 9'd1, 16'd3);
    // No units at all
    set_config(FIT_NEXT, 9'd0);
    send_item(FUNC_ALLOC, 9'd1, 16'd1);
    send_item(FUNC_TICK, 9'd0, 16'd0);
    // Spare fit code with a saturated unit count and the longest lifetime
    set_config(FIT_SPARE, 9'h1FF);
    send_item(FUNC_ALLOC, 9'd1, 16'hFFFF);
    send_item(FUNC_TICK, 9'd0, 16'd0);

    // Random phases over several settings
    for (phase = 0; phase < PHASES; phase++) begin
      set_config(fit_plan[phase], unit_plan[phase]);
      no_idle = (phase == 4 || phase == 8);
      n = (unit_plan[phase] > 9'd256) ? 256 : int'(unit_plan[phase]);
      top_size = (n < 4) ? 1 : n / 4;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 0 && k == 30) hold_request = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 25) begin
          send_item(FUNC_TICK, 9'($urandom), 16'($urandom));
        end else if (r < 30) begin
          // broken requests carry random content in the other field
          if ($urandom_range(0, 1) == 0) send_item(FUNC_ALLOC, 9'd0, 16'($urandom));
          else send_item(FUNC_ALLOC, 9'($urandom), 16'd0);
        end else if (r < 32 && phase == PHASES - 1) begin
          // long-lived grants only at the end, so they never block a later phase
          send_item(FUNC_ALLOC, 9'd1, 16'($urandom));
        end else begin
          lt = 16'($urandom_range(1, 8));
          if (r < 85) sz = 9'($urandom_range(1, top_size));
          else sz = 9'($urandom_range(1, n + 2));
          send_item(FUNC_ALLOC, sz, lt);
        end
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
